// ===== src/ftsc_pkg.sv =====
// Shared types and constants for the flow table sequence counter.
// No dependencies; used by ftsc_cell, ftsc_gather and the top level.
package ftsc_pkg;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int CNT_W  = 32;
  localparam int SLOT_W = 7;
  localparam int STAT_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_KNOWN   = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  // Event kind on the input side
  typedef enum logic {
    OP_MSG      = 1'b0,
    OP_SHUTDOWN = 1'b1
  } op_t;

  // Command strobes broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;    // compare broadcast key, register match
    logic inc_en;    // matching cell bumps its counter
    logic shift_en;  // cells at or above pos take their upper neighbor
    logic load_en;   // cell at fill position takes the new flow
  } cell_cmd_t;

  // Width of a table position
  function automatic int idx_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width of a fill count that can hold the depth itself
  function automatic int fill_w(input int depth);
    return $clog2(depth + 1);
  endfunction

endpackage

// ===== src/ftsc_cell.sv =====
// One table entry: flow key, message counter and a match flag.
// Depends on ftsc_pkg; instantiated in a row by the top level.
module ftsc_cell import ftsc_pkg::*; #(
  parameter int TABLE_DEPTH = 128,
  parameter int IDX         = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cell_cmd_t                      cmd,
  input  logic [ADDR_W-1:0]              key_addr,
  input  logic [PORT_W-1:0]              key_port,
  input  logic [fill_w(TABLE_DEPTH)-1:0] fill,
  input  logic [idx_w(TABLE_DEPTH)-1:0]  pos,
  input  logic [ADDR_W-1:0]              up_addr,
  input  logic [PORT_W-1:0]              up_port,
  input  logic [CNT_W-1:0]               up_cnt,
  output logic [ADDR_W-1:0]              addr,
  output logic [PORT_W-1:0]              port,
  output logic [CNT_W-1:0]               cnt,
  output logic                           match
);

  localparam int FW = fill_w(TABLE_DEPTH);
  localparam int IW = idx_w(TABLE_DEPTH);
  localparam logic [FW-1:0] MY_FILL = FW'(IDX);
  localparam logic [IW-1:0] MY_IDX  = IW'(IDX);

  logic occupied;
  logic hit;

  // Only entries below the fill count take part in a lookup
  assign occupied = (MY_FILL < fill);
  assign hit      = occupied && (addr == key_addr) && (port == key_port);

  // Match flag, held until the next compare
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmd.cmp_en) begin
      match <= hit;
    end
  end

  // Entry payload: load, count, or take the upper neighbor on removal
  always_ff @(posedge clk) begin
    if (cmd.load_en && (MY_FILL == fill)) begin
      addr <= key_addr;
      port <= key_port;
      cnt  <= CNT_W'(2);  // the new flow is numbered 1 now
    end else if (cmd.inc_en && match) begin
      if (cnt != CNT_MAX) begin
        cnt <= cnt + CNT_W'(1);
      end
    end else if (cmd.shift_en && (MY_IDX >= pos)) begin
      addr <= up_addr;
      port <= up_port;
      cnt  <= up_cnt;
    end
  end

endmodule

// ===== src/ftsc_gather.sv =====
// Two-stage registered reduction of the cell match flags into hit, position
// and counter. Keys are unique in the table, so at most one cell matches.
// Depends on ftsc_pkg.
module ftsc_gather import ftsc_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                          clk,
  input  logic [TABLE_DEPTH-1:0]        match,
  input  logic [CNT_W-1:0]              cnt_in [TABLE_DEPTH],
  output logic                          found,
  output logic [idx_w(TABLE_DEPTH)-1:0] pos,
  output logic [CNT_W-1:0]              cnt
);

  localparam int IW = idx_w(TABLE_DEPTH);
  localparam int GRP = 16;
  localparam int NGRP = (TABLE_DEPTH + GRP - 1) / GRP;

  logic             grp_hit_c [NGRP];
  logic [IW-1:0]    grp_pos_c [NGRP];
  logic [CNT_W-1:0] grp_cnt_c [NGRP];
  logic             grp_hit   [NGRP];
  logic [IW-1:0]    grp_pos   [NGRP];
  logic [CNT_W-1:0] grp_cnt   [NGRP];
  logic             found_c;
  logic [IW-1:0]    pos_c;
  logic [CNT_W-1:0] cnt_c;

  // First stage: OR within groups of sixteen cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_c[g] = 1'b0;
      grp_pos_c[g] = '0;
      grp_cnt_c[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < TABLE_DEPTH) begin
          if (match[g * GRP + k]) begin
            grp_hit_c[g] = 1'b1;
            grp_pos_c[g] = grp_pos_c[g] | IW'(g * GRP + k);
            grp_cnt_c[g] = grp_cnt_c[g] | cnt_in[g * GRP + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit[g] <= grp_hit_c[g];
      grp_pos[g] <= grp_pos_c[g];
      grp_cnt[g] <= grp_cnt_c[g];
    end
  end

  // Second stage: OR across the group results
  always_comb begin
    found_c = 1'b0;
    pos_c   = '0;
    cnt_c   = '0;
    for (int g = 0; g < NGRP; g++) begin
      found_c = found_c | grp_hit[g];
      pos_c   = pos_c | grp_pos[g];
      cnt_c   = cnt_c | grp_cnt[g];
    end
  end

  always_ff @(posedge clk) begin
    found <= found_c;
    pos   <= pos_c;
    cnt   <= cnt_c;
  end

endmodule

// ===== src/flow_table_sequence_counter.sv =====
// Flow table with per-flow message counters, built as a row of table cells.
// Depends on ftsc_pkg, ftsc_cell and ftsc_gather.
//
// Usage:
//   Input stream (s_*): one word per packet event. s_tuser is the event kind
//   (0 message, 1 shutdown); s_tdata carries source address and port.
//   Output stream (m_*): one word per event. m_tuser is the status code;
//   m_tdata carries the sequence number and the table slot.
//   A message from a known flow gets the flow's counter, which then counts up
//   and sticks at all ones. An unknown flow is appended with number 1, or
//   rejected with status full. A shutdown removes the flow and every later
//   entry moves down one cell, keeping the table packed.
//   Timing: an event is taken only while the sequencer is idle. It then runs
//   compare (every cell at once), two registered reduction stages, and the
//   update, which registers the result in the output register once that is
//   free; only then does the sequencer return to idle for the next event.
//   A stalled output holds its word; the next event is accepted meanwhile,
//   and its update waits until the output register is free.
//   Reset empties the table at once (fill count to zero) and drops any word
//   in flight; entry contents are not cleared.
module flow_table_sequence_counter import ftsc_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] src_addr, [47:32] src_port
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] seq_number, [38:32] slot, [39] zero
  output logic [2:0]  m_tuser    // [2:0] status
);

  localparam int IW = idx_w(TABLE_DEPTH);
  localparam int FW = fill_w(TABLE_DEPTH);
  localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED1,
    S_RED2,
    S_UPD
  } state_t;

  state_t            state;
  op_t               op;
  logic [ADDR_W-1:0] key_addr;
  logic [PORT_W-1:0] key_port;
  logic [FW-1:0]     fill_count;
  logic [FW-1:0]     fill_count_next;
  cell_cmd_t         cmd;

  status_t           out_status;
  logic [CNT_W-1:0]  out_seq;
  logic [SLOT_W-1:0] out_slot;
  logic              out_valid;
  status_t           res_status;
  logic [CNT_W-1:0]  res_seq;
  logic [IW-1:0]     res_pos;

  logic [ADDR_W-1:0]      c_addr [TABLE_DEPTH];
  logic [PORT_W-1:0]      c_port [TABLE_DEPTH];
  logic [CNT_W-1:0]       c_cnt  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] c_match;

  logic          g_found;
  logic [IW-1:0] g_pos;
  logic [CNT_W-1:0] g_cnt;

  logic in_take;
  logic out_free;
  logic upd_go;
  logic is_full;

  assign s_tready = (state == S_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign upd_go   = (state == S_UPD) && out_free;
  assign is_full  = (fill_count == FILL_MAX);

  // Update decision for the event under way
  always_comb begin
    cmd             = '0;
    cmd.cmp_en      = (state == S_CMP);
    fill_count_next = fill_count;
    res_status      = ST_UNKNOWN;
    res_seq         = '0;
    res_pos         = '0;
    if (op == OP_SHUTDOWN) begin
      if (g_found) begin
        cmd.shift_en    = upd_go;
        fill_count_next = fill_count - FW'(1);
        res_status      = ST_REMOVED;
        res_pos         = g_pos;
      end
    end else if (g_found) begin
      cmd.inc_en = upd_go;
      res_status = ST_KNOWN;
      res_seq    = g_cnt;
      res_pos    = g_pos;
    end else if (!is_full) begin
      cmd.load_en     = upd_go;
      fill_count_next = fill_count + FW'(1);
      res_status      = ST_NEW;
      res_seq         = CNT_W'(1);
      res_pos         = IW'(fill_count);
    end else begin
      res_status = ST_FULL;
    end
  end

  // Sequencer, fill count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (upd_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_CMP;
          end
        end
        S_CMP:  state <= S_RED1;
        S_RED1: state <= S_RED2;
        S_RED2: state <= S_UPD;
        S_UPD: begin
          if (out_free) begin
            fill_count <= fill_count_next;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Event key and output payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      key_addr <= s_tdata[31:0];
      key_port <= s_tdata[47:32];
      op       <= op_t'(s_tuser);
    end
    if (upd_go) begin
      out_status <= res_status;
      out_seq    <= res_seq;
      out_slot   <= SLOT_W'(res_pos);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_slot, out_seq};
  assign m_tuser  = out_status;

  // Row of table cells; on removal, each cell at or above the removed position takes its upper neighbor
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [ADDR_W-1:0] up_addr;
    logic [PORT_W-1:0] up_port;
    logic [CNT_W-1:0]  up_cnt;

    if (i + 1 < TABLE_DEPTH) begin : g_up
      assign up_addr = c_addr[i + 1];
      assign up_port = c_port[i + 1];
      assign up_cnt  = c_cnt[i + 1];
    end else begin : g_top
      assign up_addr = '0;
      assign up_port = '0;
      assign up_cnt  = '0;
    end

    ftsc_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .key_addr(key_addr),
      .key_port(key_port),
      .fill    (fill_count),
      .pos     (g_pos),
      .up_addr (up_addr),
      .up_port (up_port),
      .up_cnt  (up_cnt),
      .addr    (c_addr[i]),
      .port    (c_port[i]),
      .cnt     (c_cnt[i]),
      .match   (c_match[i])
    );
  end

  ftsc_gather #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_gather (
    .clk   (clk),
    .match (c_match),
    .cnt_in(c_cnt),
    .found (g_found),
    .pos   (g_pos),
    .cnt   (g_cnt)
  );

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_MAX)
    else $error("fill count beyond table depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_FULL)) |-> is_full)
    else $error("full status reported with room in the table");

  a_out_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_UPD))
    else $error("output word raised outside the update step");

  a_removed_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_REMOVED)) |-> (out_seq == '0))
    else $error("removal carries a sequence number");

endmodule

// ===== tb/ftsc_checker.sv =====
// Scoreboard for the flow table sequence counter: watches both streams,
// keeps its own copy of the flow table and checks every output word.
// Depends on ftsc_pkg for widths, status codes and event kinds.
`timescale 1ns / 100ps

module ftsc_checker import ftsc_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] src_addr, [47:32] src_port
  input  logic        s_tuser,   // [0] op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] seq_number, [38:32] slot, [39] zero
  input  logic [2:0]  m_tuser,   // [2:0] status
  output int          errors,
  output int          pending,
  output int          n_known,
  output int          n_new,
  output int          n_full,
  output int          n_removed,
  output int          n_unknown
);

  typedef struct packed {
    status_t             status;
    logic [CNT_W-1:0]    seq;
    logic [SLOT_W-1:0]   slot;
  } flow_result_t;

  // Shadow flow table, packed from entry 0 up
  logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
  logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
  logic [CNT_W-1:0]  tbl_cnt  [TABLE_DEPTH];
  int                tbl_fill;

  // Numbers owed to the output stream, oldest first
  flow_result_t owed_numbers[$];

  // Apply one packet event to the shadow table and return its result word
  function automatic flow_result_t next_number(input op_t op, input logic [ADDR_W-1:0] addr,
                                               input logic [PORT_W-1:0] port);
    flow_result_t res;
    int           pos;
    bit           hit;
    hit = 0;
    pos = 0;
    res.status = ST_UNKNOWN;
    res.seq    = '0;
    res.slot   = '0;
    for (int i = 0; i < tbl_fill; i++) begin
      if (!hit && tbl_addr[i] == addr && tbl_port[i] == port) begin
        hit = 1;
        pos = i;
      end
    end
    if (op == OP_SHUTDOWN) begin
      // close the gap so the table stays packed
      if (hit) begin
        for (int i = pos; i + 1 < tbl_fill; i++) begin
          tbl_addr[i] = tbl_addr[i+1];
          tbl_port[i] = tbl_port[i+1];
          tbl_cnt[i]  = tbl_cnt[i+1];
        end
        tbl_fill--;
        res.status = ST_REMOVED;
        res.slot   = pos[SLOT_W-1:0];
      end
    end else if (!hit && tbl_fill >= TABLE_DEPTH) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_KNOWN;
      if (!hit) begin
        pos           = tbl_fill;
        tbl_addr[pos] = addr;
        tbl_port[pos] = port;
        tbl_cnt[pos]  = 1;
        tbl_fill++;
        res.status    = ST_NEW;
      end
      // counter sticks at all ones
      res.seq  = tbl_cnt[pos];
      res.slot = pos[SLOT_W-1:0];
      if (tbl_cnt[pos] != CNT_MAX) tbl_cnt[pos]++;
    end
    return res;
  endfunction

  task automatic flag_field(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Compare output words first, then log newly accepted events
  always @(posedge clk) begin
    flow_result_t want;
    if (rst) begin
      tbl_fill = 0;
      owed_numbers.delete();
      errors = 0;
      n_known = 0;
      n_new = 0;
      n_full = 0;
      n_removed = 0;
      n_unknown = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_numbers.size() == 0) begin
          flag_field("unexpected word, tdata", '0, 64'(m_tdata));
        end else begin
          want = owed_numbers.pop_front();
          if (m_tuser !== want.status)
            flag_field("status", 64'(want.status), 64'(m_tuser));
          if (m_tdata[31:0] !== want.seq)
            flag_field("seq_number", 64'(want.seq), 64'(m_tdata[31:0]));
          if (m_tdata[38:32] !== want.slot)
            flag_field("slot", 64'(want.slot), 64'(m_tdata[38:32]));
          if (m_tdata[39] !== 1'b0)
            flag_field("tdata pad bit", '0, 64'(m_tdata[39]));
          case (want.status)
            ST_KNOWN:   n_known++;
            ST_NEW:     n_new++;
            ST_FULL:    n_full++;
            ST_REMOVED: n_removed++;
            default:    n_unknown++;
          endcase
        end
      end
      if (s_tvalid && s_tready)
        owed_numbers.push_back(next_number(op_t'(s_tuser), s_tdata[31:0], s_tdata[47:32]));
    end
    pending = owed_numbers.size();
  end

endmodule

// ===== tb/tb_flow_table_sequence_counter.sv =====
// Top of the flow table sequence counter testbench: clock, reset, stimulus
// and verdict. Depends on ftsc_pkg, ftsc_checker and the block itself.
`timescale 1ns / 100ps

module tb_flow_table_sequence_counter;
  import ftsc_pkg::*;

  localparam int DEPTH  = 128;
  localparam int POOL_N = 144;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;

  int errors, pending, n_known, n_new, n_full, n_removed, n_unknown;
  int tx_idle_pct, rx_idle_pct;
  int events_sent;

  // Flow keys reused across events so lookups hit
  logic [ADDR_W-1:0] pool_addr [POOL_N];
  logic [PORT_W-1:0] pool_port [POOL_N];

  flow_table_sequence_counter #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  ftsc_checker #(.TABLE_DEPTH(DEPTH)) u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending), .n_known(n_known), .n_new(n_new),
    .n_full(n_full), .n_removed(n_removed), .n_unknown(n_unknown)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver backpressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("flow_table_sequence_counter test failed");
    $finish;
  end

  // Present one event word, with an optional gap first; returns at a falling edge
  task automatic send_event(input op_t op, input logic [ADDR_W-1:0] addr,
                            input logic [PORT_W-1:0] port);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {port, addr};
    do @(posedge clk); while (!s_tready);
    events_sent++;
    @(negedge clk);
  endtask

  // Hold off until every owed word has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly pool keys, now and then a fresh random flow
  task automatic random_event(input int pool_n, input int shut_pct);
    op_t               op;
    logic [ADDR_W-1:0] a;
    logic [PORT_W-1:0] p;
    int                k;
    op = ($urandom_range(99) < shut_pct) ? OP_SHUTDOWN : OP_MSG;
    if ($urandom_range(9) == 0) begin
      a = $urandom;
      p = PORT_W'($urandom_range(16'hFFFF));
    end else begin
      k = $urandom_range(pool_n - 1);
      a = pool_addr[k];
      p = pool_port[k];
    end
    send_event(op, a, p);
    if ($urandom_range(39) == 0) drain();
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_MSG;
    rst = 1'b1;
    tx_idle_pct = 18;
    rx_idle_pct = 79;
    events_sent = 0;
    for (int k = 0; k < POOL_N; k++) begin
      pool_addr[k] = $urandom;
      pool_port[k] = PORT_W'($urandom_range(16'hFFFF));
    end
    // near misses: same address other port, same port other address
    pool_addr[1] = pool_addr[0];
    pool_port[1] = pool_port[0] ^ 16'h0001;
    pool_addr[2] = pool_addr[0] ^ 32'h8000_0000;
    pool_port[2] = pool_port[0];

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, shutdown on empty table, shift on removal
    send_event(OP_SHUTDOWN, 32'h0, 16'h0);
    send_event(OP_MSG, 32'h0, 16'h0);
    send_event(OP_MSG, 32'h0, 16'h0);
    send_event(OP_MSG, 32'hFFFF_FFFF, 16'hFFFF);
    send_event(OP_MSG, 32'h0, 16'hFFFF);
    send_event(OP_MSG, 32'hFFFF_FFFF, 16'h0);
    send_event(OP_MSG, 32'h8000_0000, 16'h8000);
    send_event(OP_MSG, 32'h0000_0001, 16'h0001);
    send_event(OP_MSG, 32'hFFFF_FFFF, 16'hFFFF);
    send_event(OP_SHUTDOWN, 32'h0, 16'h0);
    send_event(OP_MSG, 32'hFFFF_FFFF, 16'hFFFF);
    send_event(OP_SHUTDOWN, 32'h0000_0001, 16'h0001);
    send_event(OP_SHUTDOWN, 32'h0, 16'h0);
    send_event(OP_MSG, 32'h0, 16'h0);
    send_event(OP_SHUTDOWN, 32'h7FFF_FFFF, 16'h7FFF);
    send_event(OP_SHUTDOWN, 32'h0, 16'hFFFF);
    send_event(OP_SHUTDOWN, 32'hFFFF_FFFF, 16'hFFFF);
    send_event(OP_SHUTDOWN, 32'hFFFF_FFFF, 16'h0);
    send_event(OP_SHUTDOWN, 32'h8000_0000, 16'h8000);
    send_event(OP_SHUTDOWN, 32'h0, 16'h0);
    send_event(OP_MSG, 32'hA5A5_A5A5, 16'h5A5A);
    send_event(OP_SHUTDOWN, 32'hA5A5_A5A5, 16'h5A5A);
    drain();

    // Small key set: lots of repeat messages and removals
    repeat (150) random_event(16, 30);
    drain();

    // Fill past the table depth, then churn a full table
    tx_idle_pct = 79;
    rx_idle_pct = 18;
    for (int k = 0; k < POOL_N; k++) send_event(OP_MSG, pool_addr[k], pool_port[k]);
    repeat (90) random_event(POOL_N, 55);
    drain();

    // Back to back on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (150) random_event(24, 30);
    drain();
    repeat (12) @(negedge clk);

    $display("Sent %0d packet events: %0d new flows, %0d repeat messages, %0d table-full rejects,",
             events_sent, n_new, n_known, n_full);
    $display("%0d removals and %0d shutdowns of unknown flows.", n_removed, n_unknown);
    if (errors == 0) begin
      $display("flow_table_sequence_counter test passed");
    end else begin
      $display("flow_table_sequence_counter test failed");
    end
    $finish;
  end

endmodule
